// ----- src/mrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, codes and defaults for the map-reduce task dispatcher.
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam int MAX_JOBS_DEF         = 8;
  localparam int MAX_MAP_TASKS_DEF    = 16;
  localparam int MAX_REDUCE_TASKS_DEF = 16;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  typedef enum logic [2:0] {
    CMD_SUBMIT = 3'd0,
    CMD_POLL   = 3'd1,
    CMD_GET    = 3'd2,
    CMD_FINISH = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  localparam logic [1:0] FLAG_ASSIGNED = 2'b01;
  localparam logic [1:0] FLAG_SUCCESS  = 2'b10;

  typedef struct packed {
    logic [15:0] tag;
    logic [1:0]  flags;
    logic [31:0] stamp;
  } task_entry_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] job_id;
    logic [4:0]  map_count;
    logic [4:0]  reduce_count;
    logic        app_known;
    logic [3:0]  task_index;
    logic        is_reduce;
    logic        task_ok;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] result_job;
    logic [3:0]  result_task;
    logic        result_reduce;
    logic        wait_res;
    logic        job_done;
    logic        job_failed;
    logic [4:0]  map_total;
    logic [4:0]  reduce_total;
  } rsp_t;

endpackage

// ----- src/mrd_req_if.sv -----
// ----------------------------------------------------------------------------
// mrd_req_if
// Request channel: valid, ready and one request.
// ----------------------------------------------------------------------------
interface mrd_req_if import mrd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/mrd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mrd_rsp_if
// Response channel: valid, ready and one response.
// ----------------------------------------------------------------------------
interface mrd_rsp_if import mrd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/map_reduce_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// map_reduce_task_dispatcher
// Job table in flip-flops, task flags and stamps in a tagged task memory.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid/ready      | command, job, counts, finish info
//   rsp     | out | valid/ready      | status, task, poll bits, totals
//   cfg     | in  | cfg_we           | task_timeout (16 bits)
//
// Steps: poll, tick and a rejected submit go straight to the response; an
// accepted submit first clears the slot's map and reduce task entries; finish
// updates the job, but not for an unknown job, a job no longer queued or an index out of range.
// Get task: each round scans all job slots for the oldest unused queued job,
// loads it and checks its tasks in turn; when no job is left, it answers wait.
// Reset clears the job valid bits; submit writes task entries before use.
// Stalls: ready only in idle; a stalled response holds in the output register.
// ----------------------------------------------------------------------------
module map_reduce_task_dispatcher import mrd_pkg::*; #(
  parameter int MaxJobs        = MAX_JOBS_DEF,
  parameter int MaxMapTasks    = MAX_MAP_TASKS_DEF,
  parameter int MaxReduceTasks = MAX_REDUCE_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mrd_req_if.sink     req,
  mrd_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int SW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int TD = (MaxMapTasks > MaxReduceTasks) ? MaxMapTasks : MaxReduceTasks;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;
  localparam int CW = $clog2(TD + 1);
  localparam int AW = 1 + SW + TW;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_PREP = 7'b0000100,
    ST_TASK = 7'b0001000,
    ST_FIN  = 7'b0010000,
    ST_RESP = 7'b0100000,
    ST_CLR  = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0] task_timeout;
  logic [15:0] next_number;
  logic [SW-1:0] next_slot;
  logic [31:0] now_ticks;

  logic [MaxJobs-1:0] slot_valid, slot_queued, slot_done, slot_failed, used;
  logic [15:0] slot_number [MaxJobs];
  logic [CW-1:0] slot_map_total [MaxJobs];
  logic [CW-1:0] slot_reduce_total [MaxJobs];
  logic [CW-1:0] slot_map_fin [MaxJobs];
  logic [CW-1:0] slot_reduce_fin [MaxJobs];

  logic [SW-1:0] sidx, best, tslot;
  logic          found;
  logic [15:0]   best_age;
  logic          tred;
  logic [15:0]   tnum;
  logic [CW-1:0] ttotal, tmap, tred_total, ti;
  logic          chk;
  logic [TW-1:0] chk_idx;
  logic          fok;
  logic [AW-1:0] faddr;
  rsp_t          res;
  rsp_t          od;
  logic          ov;

  // job lookup by number
  logic [SW-1:0] match_slot;
  logic          match_hit;
  always_comb begin
    match_slot = '0;
    match_hit  = 1'b0;
    for (int s = 0; s < MaxJobs; s++) begin
      if (!match_hit && slot_valid[s] && slot_number[s] == req.data.job_id) begin
        match_hit  = 1'b1;
        match_slot = SW'(s);
      end
    end
  end

  logic [SW-1:0] sel;
  always_comb begin
    case (state)
      ST_IDLE: sel = (req.data.command == CMD_SUBMIT) ? next_slot : match_slot;
      ST_SCAN: sel = sidx;
      default: sel = tslot;
    endcase
  end

  logic        accept;
  logic [15:0] age;
  logic        elig, take;
  logic [SW-1:0] nbest;
  assign accept = req.valid && req.ready;
  assign age    = next_number - slot_number[sel];
  assign elig   = !used[sel] && slot_valid[sel] && slot_queued[sel];
  assign take   = elig && (!found || age > best_age);
  assign nbest  = take ? sidx : best;

  // task memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, task_addr;
  task_entry_t   mem_wdata, mem_rdata;
  logic [1:0]    eflags;
  logic          task_hit;

  assign task_addr = {tred, tslot, ti[TW-1:0]};
  assign mem_raddr = (state == ST_IDLE)
                   ? {req.data.is_reduce, match_slot, TW'(req.data.task_index)}
                   : task_addr;
  assign eflags   = (mem_rdata.tag == tnum) ? mem_rdata.flags : 2'b00;
  assign task_hit = !eflags[0] ||
                    (!eflags[1] && (now_ticks - mem_rdata.stamp) > {16'd0, task_timeout});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = faddr;
    mem_wdata = '{tag: tnum, flags: eflags | FLAG_SUCCESS, stamp: mem_rdata.stamp};
    if (state == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = task_addr;
      mem_wdata = '{tag: tnum, flags: 2'b00, stamp: 32'd0};
    end else if (state == ST_TASK && chk && task_hit) begin
      mem_we    = 1'b1;
      mem_waddr = {tred, tslot, chk_idx};
      mem_wdata = '{tag: tnum, flags: eflags | FLAG_ASSIGNED, stamp: now_ticks};
    end else if (state == ST_FIN && !eflags[1] && fok) begin
      mem_we = 1'b1;
    end
  end

  mrd_task_mem #(.AddrW(AW)) u_task_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = ov;
  assign rsp.data  = od;

  logic [CW-1:0] mcount, rcount, fin_total, rfin_next;
  assign mcount = (int'(req.data.map_count) > MaxMapTasks) ? CW'(MaxMapTasks)
                                                          : CW'(req.data.map_count);
  assign rcount = (int'(req.data.reduce_count) > MaxReduceTasks) ? CW'(MaxReduceTasks)
                                                                : CW'(req.data.reduce_count);
  assign fin_total = req.data.is_reduce ? slot_reduce_total[sel] : slot_map_total[sel];
  assign rfin_next = slot_reduce_fin[sel] + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      task_timeout <= TIMEOUT_RST;
      next_number  <= '0;
      next_slot    <= '0;
      now_ticks    <= '0;
      slot_valid   <= '0;
      slot_queued  <= '0;
      res          <= '0;
      ov           <= 1'b0;
    end else begin
      if (cfg_we) begin
        task_timeout <= cfg_data;
      end
      if (ov && rsp.ready && state != ST_RESP) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.data.command)
              CMD_SUBMIT: begin
                next_number <= next_number + 16'd1;
                next_slot   <= (next_number == 16'hFFFF || next_slot == SW'(MaxJobs - 1))
                             ? '0 : next_slot + 1'b1;
                if ((slot_valid[sel] && slot_queued[sel]) || !req.data.app_known) begin
                  res.status <= 1'b1;
                  state      <= ST_RESP;
                end else begin
                  slot_valid[sel]        <= 1'b1;
                  slot_queued[sel]       <= 1'b1;
                  slot_number[sel]       <= next_number;
                  slot_map_total[sel]    <= mcount;
                  slot_reduce_total[sel] <= rcount;
                  slot_map_fin[sel]      <= '0;
                  slot_reduce_fin[sel]   <= '0;
                  slot_done[sel]         <= 1'b0;
                  slot_failed[sel]       <= 1'b0;
                  res.result_job         <= next_number;
                  tslot                  <= sel;
                  tnum                   <= next_number;
                  tred                   <= 1'b0;
                  ti                     <= '0;
                  state                  <= ST_CLR;
                end
              end
              CMD_POLL: begin
                if (!match_hit) begin
                  res.status <= 1'b1;
                end else begin
                  res.job_done   <= slot_done[sel];
                  res.job_failed <= slot_failed[sel];
                end
                state <= ST_RESP;
              end
              CMD_GET: begin
                used     <= '0;
                sidx     <= '0;
                found    <= 1'b0;
                best_age <= '0;
                best     <= '0;
                state    <= ST_SCAN;
              end
              CMD_FINISH: begin
                if (!match_hit) begin
                  res.status <= 1'b1;
                  state      <= ST_RESP;
                end else if (slot_queued[sel] &&
                             int'(req.data.task_index) < int'(fin_total)) begin
                  tslot <= sel;
                  tred  <= req.data.is_reduce;
                  tnum  <= req.data.job_id;
                  fok   <= req.data.task_ok;
                  faddr <= mem_raddr;
                  state <= ST_FIN;
                end else begin
                  state <= ST_RESP;
                end
              end
              CMD_TICK: begin
                now_ticks <= now_ticks + 32'd1;
                state     <= ST_RESP;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_CLR: begin
          if (ti == CW'(TD - 1)) begin
            ti   <= '0;
            tred <= 1'b1;
            if (tred) begin
              state <= ST_RESP;
            end
          end else begin
            ti <= ti + 1'b1;
          end
        end
        ST_SCAN: begin
          if (take) begin
            found    <= 1'b1;
            best     <= sidx;
            best_age <= age;
          end
          sidx <= sidx + 1'b1;
          if (sidx == SW'(MaxJobs - 1)) begin
            if (found || take) begin
              tslot       <= nbest;
              used[nbest] <= 1'b1;
              state       <= ST_PREP;
            end else begin
              res.wait_res <= 1'b1;
              state        <= ST_RESP;
            end
          end
        end
        ST_PREP: begin
          tred       <= (slot_map_fin[sel] == slot_map_total[sel]);
          ttotal     <= (slot_map_fin[sel] == slot_map_total[sel])
                      ? slot_reduce_total[sel] : slot_map_total[sel];
          tnum       <= slot_number[sel];
          tmap       <= slot_map_total[sel];
          tred_total <= slot_reduce_total[sel];
          ti         <= '0;
          chk        <= 1'b0;
          state      <= ST_TASK;
        end
        ST_TASK: begin
          if (chk && task_hit) begin
            res.result_job    <= tnum;
            res.result_task   <= 4'(chk_idx);
            res.result_reduce <= tred;
            res.map_total     <= 5'(tmap);
            res.reduce_total  <= 5'(tred_total);
            state             <= ST_RESP;
          end else if (ti < ttotal) begin
            chk     <= 1'b1;
            chk_idx <= ti[TW-1:0];
            ti      <= ti + 1'b1;
          end else begin
            sidx     <= '0;
            found    <= 1'b0;
            best_age <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_FIN: begin
          state <= ST_RESP;
          if (!eflags[1]) begin
            if (fok) begin
              if (tred) begin
                slot_reduce_fin[sel] <= rfin_next;
                if (rfin_next == slot_reduce_total[sel]) begin
                  slot_done[sel]   <= 1'b1;
                  slot_queued[sel] <= 1'b0;
                end
              end else begin
                slot_map_fin[sel] <= slot_map_fin[sel] + 1'b1;
              end
            end else begin
              slot_done[sel]   <= 1'b1;
              slot_failed[sel] <= 1'b1;
              slot_queued[sel] <= 1'b0;
            end
          end
        end
        ST_RESP: begin
          if (!ov || rsp.ready) begin
            ov    <= 1'b1;
            od    <= res;
            res   <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mrd_task_mem.sv -----
// ----------------------------------------------------------------------------
// mrd_task_mem
// Task table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrd_task_mem import mrd_pkg::*; #(
  parameter int AddrW = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  task_entry_t       wdata,
  input  logic [AddrW-1:0]  raddr,
  output task_entry_t       rdata
);

  task_entry_t mem [2**AddrW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mrd_checker.sv -----
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module mrd_checker import mrd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped or changed under stall");

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status |-> rsp_data.result_job == 16'd0 && !rsp_data.wait_res)
    else $error("rejected request carries a job");

  a_fail_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.job_failed |-> rsp_data.job_done)
    else $error("failed job not reported done");

  a_wait_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.wait_res |-> rsp_data.result_job == 16'd0 &&
    !rsp_data.result_reduce && rsp_data.map_total == 5'd0)
    else $error("wait response carries a task");

endmodule

bind map_reduce_task_dispatcher mrd_checker u_mrd_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- verif/tb_map_reduce_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// tb_map_reduce_task_dispatcher
// Self-checking bench for the job table dispatcher: requests are generated
// up front, driven with random gaps, and every response is checked against
// an in-bench job table that tracks slots, task flags, stamps and the tick
// count, across several task timeout settings.
// ----------------------------------------------------------------------------
module tb_map_reduce_task_dispatcher;
  import mrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJOBS  = MAX_JOBS_DEF;
  localparam int NMAP   = MAX_MAP_TASKS_DEF;
  localparam int NRED   = MAX_REDUCE_TASKS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  mrd_req_if req_ch ();
  mrd_rsp_if rsp_ch ();

  map_reduce_task_dispatcher u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // job table mirror
  logic [15:0] tmo;
  logic [15:0] nxt_num;
  logic [31:0] ticks;
  logic        s_valid [NJOBS];
  logic        s_queued [NJOBS];
  logic [15:0] s_num [NJOBS];
  logic [4:0]  s_mtot [NJOBS];
  logic [4:0]  s_rtot [NJOBS];
  logic [4:0]  s_mfin [NJOBS];
  logic [4:0]  s_rfin [NJOBS];
  logic [1:0]  s_df [NJOBS];
  logic [1:0]  m_flg [NJOBS][NMAP];
  logic [31:0] m_stp [NJOBS][NMAP];
  logic [1:0]  r_flg [NJOBS][NRED];
  logic [31:0] r_stp [NJOBS][NRED];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   sent_cnt = 0;
  int   acc_cnt = 0;
  int   stall_cnt = 0;
  int   gen_submits = 0;

  function automatic int pick_task(input int s, input bit red);
    logic [1:0]  f;
    logic [31:0] st;
    int total;
    total = red ? s_rtot[s] : s_mtot[s];
    for (int i = 0; i < total; i++) begin
      f  = red ? r_flg[s][i] : m_flg[s][i];
      st = red ? r_stp[s][i] : m_stp[s][i];
      if ((f & FLAG_ASSIGNED) == 0) return i;
      if ((f & FLAG_SUCCESS) == 0 && (ticks - st) > {16'd0, tmo}) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t dispatch_outcome(input req_t r);
    rsp_t o;
    int s, best, t;
    logic [15:0] age, best_age;
    bit used [NJOBS];
    bit red;
    logic [4:0] mc, rc;
    o = '0;
    case (r.command)
      CMD_SUBMIT: begin
        s = nxt_num % NJOBS;
        o.result_job = nxt_num;
        nxt_num = nxt_num + 16'd1;
        if ((s_valid[s] && s_queued[s]) || !r.app_known) begin
          o.status = 1'b1;
          o.result_job = '0;
        end else begin
          mc = (r.map_count > NMAP) ? 5'(NMAP) : r.map_count;
          rc = (r.reduce_count > NRED) ? 5'(NRED) : r.reduce_count;
          s_valid[s] = 1; s_queued[s] = 1; s_num[s] = o.result_job;
          s_mtot[s] = mc; s_rtot[s] = rc; s_mfin[s] = 0; s_rfin[s] = 0; s_df[s] = 0;
          for (int i = 0; i < NMAP; i++) m_flg[s][i] = 0;
          for (int i = 0; i < NRED; i++) r_flg[s][i] = 0;
        end
      end
      CMD_POLL: begin
        s = r.job_id % NJOBS;
        if (!s_valid[s] || s_num[s] != r.job_id) o.status = 1'b1;
        else begin
          o.job_done = s_df[s][0];
          o.job_failed = s_df[s][1];
        end
      end
      CMD_GET: begin
        o.wait_res = 1'b1;
        for (int k = 0; k < NJOBS; k++) used[k] = 0;
        for (int rnd = 0; rnd < NJOBS; rnd++) begin
          best = -1; best_age = 0;
          for (int k = 0; k < NJOBS; k++) begin
            if (used[k] || !s_valid[k] || !s_queued[k]) continue;
            age = nxt_num - s_num[k];
            if (best < 0 || age > best_age) begin
              best = k; best_age = age;
            end
          end
          if (best < 0) break;
          used[best] = 1;
          red = (s_mfin[best] == s_mtot[best]);
          t = pick_task(best, red);
          if (t >= 0) begin
            if (red) begin
              r_flg[best][t] |= FLAG_ASSIGNED; r_stp[best][t] = ticks;
            end else begin
              m_flg[best][t] |= FLAG_ASSIGNED; m_stp[best][t] = ticks;
            end
            o.wait_res = 1'b0;
            o.result_job = s_num[best];
            o.result_task = 4'(t);
            o.result_reduce = red;
            o.map_total = s_mtot[best];
            o.reduce_total = s_rtot[best];
            break;
          end
        end
      end
      CMD_FINISH: begin
        s = r.job_id % NJOBS;
        if (!s_valid[s] || s_num[s] != r.job_id) o.status = 1'b1;
        else if (s_queued[s]) begin
          if (r.is_reduce ? (r.task_index < s_rtot[s]) : (r.task_index < s_mtot[s])) begin
            if (r.is_reduce ? (r_flg[s][r.task_index] & FLAG_SUCCESS) == 0
                            : (m_flg[s][r.task_index] & FLAG_SUCCESS) == 0) begin
              if (r.task_ok) begin
                if (r.is_reduce) begin
                  r_flg[s][r.task_index] |= FLAG_SUCCESS;
                  s_rfin[s]++;
                  if (s_rfin[s] == s_rtot[s]) begin
                    s_df[s] = 2'b01; s_queued[s] = 0;
                  end
                end else begin
                  m_flg[s][r.task_index] |= FLAG_SUCCESS;
                  s_mfin[s]++;
                end
              end else begin
                s_df[s] = 2'b11; s_queued[s] = 0;
              end
            end
          end
        end
      end
      CMD_TICK: ticks = ticks + 32'd1;
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_field(input string name, input int got, input int want);
    if (got != want) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, name, got, want);
      errors++;
    end
  endtask

  initial begin
    tmo = TIMEOUT_RST; nxt_num = 0; ticks = 0;
    for (int i = 0; i < NJOBS; i++) begin
      s_valid[i] = 0; s_queued[i] = 0;
    end
  end

  // monitor: predict on request, check on response
  always @(posedge clk) begin
    rsp_t w;
    if (!rst) begin
      if (cfg_we) tmo = cfg_data;
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(dispatch_outcome(req_ch.data));
        acc_cnt <= acc_cnt + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("mismatch at %0t: response with none outstanding", $realtime);
          errors++;
        end else begin
          w = expected_rsps.pop_front();
          report_field("status", rsp_ch.data.status, w.status);
          report_field("result_job", rsp_ch.data.result_job, w.result_job);
          report_field("result_task", rsp_ch.data.result_task, w.result_task);
          report_field("result_reduce", rsp_ch.data.result_reduce, w.result_reduce);
          report_field("wait_res", rsp_ch.data.wait_res, w.wait_res);
          report_field("job_done", rsp_ch.data.job_done, w.job_done);
          report_field("job_failed", rsp_ch.data.job_failed, w.job_failed);
          report_field("map_total", rsp_ch.data.map_total, w.map_total);
          report_field("reduce_total", rsp_ch.data.reduce_total, w.reduce_total);
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // driver: hold the request until taken, then advance
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      if (!(req_ch.valid && acc_cnt != sent_cnt)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_reqs.pop_front();
          sent_cnt <= sent_cnt + 1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic req_t mk(input logic [2:0] c, input logic [15:0] id,
                              input logic [4:0] mc, input logic [4:0] rc,
                              input logic ak, input logic [3:0] ti,
                              input logic ir, input logic ok);
    req_t r;
    r.command = c; r.job_id = id; r.map_count = mc; r.reduce_count = rc;
    r.app_known = ak; r.task_index = ti; r.is_reduce = ir; r.task_ok = ok;
    if (c == CMD_SUBMIT) gen_submits++;
    return r;
  endfunction

  function automatic req_t random_req();
    int p;
    logic [15:0] id;
    logic [2:0] c;
    p = $urandom_range(0, 99);
    id = ($urandom_range(0, 99) < 85) ? 16'(gen_submits - $urandom_range(1, 9))
                                      : 16'($urandom);
    if (p < 15) c = CMD_SUBMIT;
    else if (p < 25) c = CMD_POLL;
    else if (p < 58) c = CMD_GET;
    else if (p < 85) c = CMD_FINISH;
    else if (p < 97) c = CMD_TICK;
    else c = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    return mk(c, id,
              ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4)),
              ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3)),
              $urandom_range(0, 99) < 95,
              ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
              1'($urandom), $urandom_range(0, 99) < 90);
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] tmos [4];
    tmos = '{16'd0, 16'hFFFF, 16'd10, 16'd3};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(mk(CMD_POLL, 16'hFFFF, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_GET, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_SUBMIT, 0, 5'd31, 5'd31, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_SUBMIT, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_SUBMIT, 0, 1, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_SUBMIT, 0, 0, 1, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_GET, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_GET, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd3, 0, 0, 1, 0, 1, 1));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd3, 0, 0, 1, 0, 1, 1));
    pending_reqs.push_back(mk(CMD_POLL, 16'd3, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd0, 0, 0, 1, 4'd15, 1, 1));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd0, 0, 0, 1, 0, 0, 1));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd0, 0, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_POLL, 16'd0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_FINISH, 16'd0, 0, 0, 1, 2, 0, 1));
    pending_reqs.push_back(mk(CMD_FINISH, 16'hABCD, 0, 0, 1, 0, 0, 1));
    pending_reqs.push_back(mk(CMD_POLL, 16'd1, 0, 0, 1, 0, 0, 0));
    for (int i = 0; i < 12; i++) pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_GET, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_RSVD_HI, 16'hFFFF, 5'd31, 5'd31, 1, 4'd15, 1, 1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_timeout(tmos[ph]);
      case (ph)
        0: begin send_idle = 6; recv_idle = 69; end
        1: begin send_idle = 69; recv_idle = 6; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < 500; i++) pending_reqs.push_back(random_req());
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
